@@ rtl/svfm_pkg.sv @@
// ----------------------------------------------------------------------------
// svfm_pkg: shared types, codes and arithmetic helpers
// Register indexes, sequencer step codes, the configuration bundle and the
// rounding and saturation helpers used by the filter datapath.
// ----------------------------------------------------------------------------
package svfm_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_F      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_Q   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS      = 3'd4;

   localparam logic [15:0] COEF_F_RST    = 16'd4667;
   localparam logic [15:0] DAMPING_Q_RST = 16'd16548;
   localparam logic [15:0] WET_GAIN_RST  = 16'd32768;
   localparam logic [15:0] ONE_Q15       = 16'd32768;
   localparam logic [15:0] DAMP_MIN      = 16'd327;

   typedef enum logic [1:0] {
      MODE_LOW  = 2'd0,
      MODE_HIGH = 2'd1,
      MODE_BAND = 2'd2,
      MODE_RAW  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0] coef_f;
      logic [15:0] damping_q;
      logic [15:0] wet_gain;
      mode_type    filter_mode;
      logic        bypass;
   } cfg_type;

   // One datapath operation per cycle
   typedef enum logic [2:0] {
      STEP_NONE     = 3'd0,
      STEP_MUL_LOW  = 3'd1,  // prod = f * band
      STEP_LOW      = 3'd2,  // low update, prod = q * band
      STEP_HIGH     = 3'd3,  // high = x - low - q*band
      STEP_MUL_BAND = 3'd4,  // prod = f * high
      STEP_BAND     = 3'd5,  // band update, prod = dry * x
      STEP_MIX      = 3'd6   // acc = dry * x, prod = wet * sel
   } step_type;

   typedef struct packed {
      step_type step;
      logic     load_in;
      logic     load_out;
   } cmd_type;

   typedef struct packed {
      logic bypass;
   } status_type;

   // Round half up, then drop 15 fraction bits
   function automatic logic signed [25:0] rnd_q15(input logic signed [40:0] p);
      logic signed [40:0] s;
      s = p + 41'sd16384;
      return 26'(s >>> 15);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      logic signed [23:0] r;
      if (v > 28'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
      logic signed [15:0] r;
      if (v > 21'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/svfm_csr.sv @@
// ----------------------------------------------------------------------------
// svfm_csr: configuration registers
// Holds tuning, damping, mix, mode and bypass; takes one write per cycle.
// ----------------------------------------------------------------------------
module svfm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [svfm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data,
   output logic                          csr_ready,
   output svfm_pkg::cfg_type             cfg
);
   import svfm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_F:      cfg_in.coef_f      = csr_data;
            CSR_DAMPING_Q:   cfg_in.damping_q   = csr_data;
            CSR_WET_GAIN:    cfg_in.wet_gain    = csr_data;
            CSR_FILTER_MODE: cfg_in.filter_mode = mode_type'(csr_data[1:0]);
            CSR_BYPASS:      cfg_in.bypass      = csr_data[0];
            default:         cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_f      <= COEF_F_RST;
         cfg_ff.damping_q   <= DAMPING_Q_RST;
         cfg_ff.wet_gain    <= WET_GAIN_RST;
         cfg_ff.filter_mode <= MODE_LOW;
         cfg_ff.bypass      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/svfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// svfm_ctrl: sequencer
// Steps one sample through the filter and mix (or skips them in bypass),
// then hands the word to the output register.
// ----------------------------------------------------------------------------
module svfm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  svfm_pkg::status_type status,
   output svfm_pkg::cmd_type    cmd
);
   import svfm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LOW,
      ST_LOW,
      ST_HIGH,
      ST_MUL_BAND,
      ST_BAND,
      ST_MIX,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '{step: STEP_NONE, load_in: 1'b0, load_out: 1'b0};
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_in = 1'b1;
               state_in    = status.bypass ? ST_OUT : ST_MUL_LOW;
            end
         end
         ST_MUL_LOW: begin
            cmd.step = STEP_MUL_LOW;
            state_in = ST_LOW;
         end
         ST_LOW: begin
            cmd.step = STEP_LOW;
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            cmd.step = STEP_HIGH;
            state_in = ST_MUL_BAND;
         end
         ST_MUL_BAND: begin
            cmd.step = STEP_MUL_BAND;
            state_in = ST_BAND;
         end
         ST_BAND: begin
            cmd.step = STEP_BAND;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.step = STEP_MIX;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/svfm_dp.sv @@
// ----------------------------------------------------------------------------
// svfm_dp: filter datapath
// One shared 17x24 multiplier, the Q4.20 integrators and the output register.
// ----------------------------------------------------------------------------
module svfm_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  svfm_pkg::cmd_type    cmd,
   input  svfm_pkg::cfg_type    cfg,
   input  logic signed [15:0]   sample_in,
   output svfm_pkg::status_type status,
   output logic signed [15:0]   out_sample
);
   import svfm_pkg::*;

   logic signed [15:0] sample_ff;
   logic signed [23:0] x_ff;
   logic signed [23:0] low_ff,  low_in;
   logic signed [23:0] band_ff, band_in;
   logic signed [23:0] high_ff, high_in;
   logic signed [40:0] prod_ff, prod_in;
   logic signed [40:0] acc_ff,  acc_in;
   logic signed [15:0] out_ff;

   logic [15:0]        q_eff;
   logic [15:0]        wet_eff;
   logic [15:0]        dry;
   logic [15:0]        mul_a;
   logic signed [23:0] mul_b;
   logic signed [16:0] mul_a_s;
   logic signed [40:0] mul_res;
   logic signed [23:0] sel;
   logic signed [25:0] prod_rnd;
   logic signed [40:0] mix_sum;
   logic signed [20:0] mix_shift;
   logic signed [15:0] y;

   assign status.bypass = cfg.bypass;
   assign out_sample    = out_ff;

   assign q_eff   = (cfg.damping_q < DAMP_MIN) ? DAMP_MIN : cfg.damping_q;
   assign wet_eff = (cfg.wet_gain > ONE_Q15) ? ONE_Q15 : cfg.wet_gain;
   assign dry     = ONE_Q15 - wet_eff;

   always_comb begin
      unique case (cfg.filter_mode)
         MODE_LOW:  sel = low_ff;
         MODE_HIGH: sel = high_ff;
         MODE_BAND: sel = band_ff;
         MODE_RAW:  sel = x_ff;
         default:   sel = x_ff;
      endcase
   end

   // Operand select for the shared multiplier
   always_comb begin
      unique case (cmd.step)
         STEP_MUL_LOW:  begin mul_a = cfg.coef_f; mul_b = band_ff; end
         STEP_LOW:      begin mul_a = q_eff;      mul_b = band_ff; end
         STEP_MUL_BAND: begin mul_a = cfg.coef_f; mul_b = high_ff; end
         STEP_BAND:     begin mul_a = dry;        mul_b = x_ff;    end
         STEP_MIX:      begin mul_a = wet_eff;    mul_b = sel;     end
         default:       begin mul_a = cfg.coef_f; mul_b = band_ff; end
      endcase
   end

   assign mul_a_s  = $signed({1'b0, mul_a});
   assign mul_res  = mul_a_s * mul_b;
   assign prod_rnd = rnd_q15(prod_ff);

   always_comb begin
      low_in  = low_ff;
      band_in = band_ff;
      high_in = high_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      unique case (cmd.step)
         STEP_MUL_LOW: prod_in = mul_res;
         STEP_LOW: begin
            low_in  = sat24(28'(low_ff) + 28'(prod_rnd));
            prod_in = mul_res;
         end
         STEP_HIGH: high_in = sat24(28'(x_ff) - 28'(low_ff) - 28'(prod_rnd));
         STEP_MUL_BAND: prod_in = mul_res;
         STEP_BAND: begin
            band_in = sat24(28'(band_ff) + 28'(prod_rnd));
            prod_in = mul_res;
         end
         STEP_MIX: begin
            acc_in  = prod_ff;
            prod_in = mul_res;
         end
         default: ;
      endcase
   end

   // Mix rounding: add half an LSB of Q1.15 and drop 20 bits
   assign mix_sum   = acc_ff + prod_ff + 41'sd524288;
   assign mix_shift = 21'(mix_sum >>> 20);
   assign y         = cfg.bypass ? sample_ff : sat16(mix_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         band_ff <= '0;
      end else begin
         low_ff  <= low_in;
         band_ff <= band_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.load_in) begin
         sample_ff <= sample_in;
         x_ff      <= 24'(sample_in) <<< 5;
      end
      if (cmd.load_out) begin
         out_ff <= y;
      end
   end

endmodule

@@ rtl/state_variable_filter_mix_core.sv @@
// ----------------------------------------------------------------------------
// state_variable_filter_mix_core: state variable filter with wet/dry mix
// Chamberlin filter on a mono Q1.15 sample, mode select and wet/dry mix,
// with both stereo outputs carrying the same word.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_sample_in
//   rsp_     out        rsp_valid/rsp_stall  rsp_out_left, rsp_out_right
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// A filtered word goes from the accept through six steps around the single
// shared multiplier and is then loaded into the output register.
// A bypassed word skips the steps. The next word is taken once the sequencer
// is back in idle, even while the previous result still waits on rsp_stall;
// a full output register holds the sequencer in its output state.
// Synchronous reset clears the integrators, the configuration registers and the sequencer.
// ----------------------------------------------------------------------------
module state_variable_filter_mix_core (
   input  logic                          clock,
   input  logic                          reset,
   // input samples
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_sample_in,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_out_left,
   output logic signed [15:0]            rsp_out_right,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [svfm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);
   import svfm_pkg::*;

   cfg_type            cfg;
   cmd_type            cmd;
   status_type         status;
   logic signed [15:0] out_sample;

   // Configuration registers
   svfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   // Sequencer: owns both handshakes and the step order
   svfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: integrators, shared multiplier, mix and output word
   svfm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .sample_in  (req_sample_in),
      .status     (status),
      .out_sample (out_sample)
   );

   // Mono source: drive both sides from the same word
   assign rsp_out_left  = out_sample;
   assign rsp_out_right = out_sample;

endmodule
